FILE: hdl/histogram_equalizer_defines.svh
// Assertion macros shared by the histogram equalizer RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef HISTOGRAM_EQUALIZER_DEFINES_SVH
`define HISTOGRAM_EQUALIZER_DEFINES_SVH

// A property checked on every rising clock edge outside reset.
`define HEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define HEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  `HEQ_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

FILE: hdl/heq_pkg.sv
`timescale 1ns / 1ps

package heq_pkg;

  // Image geometry.
  localparam int LEVEL_COUNT     = 256;
  localparam int MAX_PIXELS_LOG2 = 24;

  // Field widths fixed by the interface.
  localparam int PIXEL_W  = 8;
  localparam int OPCODE_W = 2;
  localparam int OUT_W    = 8;
  localparam int SIZE_W   = 25;

  // Derived widths.
  localparam int LEVEL_BITS = $clog2(LEVEL_COUNT);
  localparam int BIN_W      = MAX_PIXELS_LOG2 + 1;
  localparam int CUM_W      = BIN_W + LEVEL_BITS;
  localparam int NUM_W      = SIZE_W + LEVEL_BITS + 1;
  localparam int DSH_W      = SIZE_W + LEVEL_BITS;
  localparam int WIDE_W     = CUM_W + SIZE_W;
  localparam int STEP_W     = $clog2(LEVEL_BITS + 1);

  // Scaling constant of the normalisation, twice the top level.
  localparam int TWO_MAX_LEVEL = 2 * (LEVEL_COUNT - 1);

  localparam logic [LEVEL_BITS-1:0] MAX_LEVEL     = LEVEL_BITS'(LEVEL_COUNT - 1);
  localparam logic [OUT_W-1:0]      MAX_LEVEL_OUT = OUT_W'(LEVEL_COUNT - 1);
  localparam logic [BIN_W-1:0]      BIN_MAX       = {BIN_W{1'b1}};

  // Configuration port.
  localparam int   APB_ADDR_W     = 3;
  localparam int   APB_DATA_W     = 32;
  localparam logic REG_IMAGE_SIZE = 1'b0;

  // Item operations.
  typedef enum logic [OPCODE_W-1:0] {
    OP_COUNT = 2'd0,
    OP_MAP   = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CNT_RD,
    ST_CNT_WR,
    ST_BLD_RD,
    ST_BLD_ACC,
    ST_BLD_NUM,
    ST_BLD_DIV,
    ST_BLD_WR,
    ST_MAP_RD,
    ST_MAP_OUT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic lvl_load;
    logic hist_rd;
    logic rd_bld;
    logic hist_inc;
    logic hist_clr;
    logic bld_start;
    logic cum_acc;
    logic num_load;
    logic div_step;
    logic lut_wr;
    logic bld_next;
    logic lut_rd;
    logic out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic bld_last;
    logic div_last;
  } dp_sts_t;

  // Pixel to histogram level, clamped to the top level.
  function automatic logic [LEVEL_BITS-1:0] level_of(logic [PIXEL_W-1:0] pixel);
    logic [PIXEL_W+LEVEL_BITS-1:0] wide;
    wide = {{LEVEL_BITS{1'b0}}, pixel};
    if (wide > (PIXEL_W + LEVEL_BITS)'(LEVEL_COUNT - 1)) begin
      return MAX_LEVEL;
    end
    return wide[LEVEL_BITS-1:0];
  endfunction

endpackage

FILE: hdl/heq_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module heq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/heq_datapath.sv
`timescale 1ns / 1ps

module heq_datapath import heq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  output dp_sts_t            sts_o,
  input  logic [PIXEL_W-1:0] pixel_i,
  input  logic [SIZE_W-1:0]  image_size_i,
  output logic [OUT_W-1:0]   mapped_pixel_o
);

  logic [LEVEL_BITS-1:0] lvl_q;
  logic [LEVEL_BITS-1:0] bld_lvl_q;
  logic [LEVEL_COUNT-1:0] hist_vld_q;
  logic                  rd_vld_q;
  logic [CUM_W-1:0]      cum_q;
  logic [NUM_W-1:0]      rem_q;
  logic [DSH_W-1:0]      dsh_q;
  logic [LEVEL_BITS-1:0] quot_q;
  logic [STEP_W-1:0]     step_q;
  logic                  sat_q;
  logic [OUT_W-1:0]      out_q;

  logic [LEVEL_BITS-1:0] hist_raddr;
  logic [BIN_W-1:0]      hist_rdata;
  logic [BIN_W-1:0]      bin_cur;
  logic [BIN_W-1:0]      bin_inc;
  logic [SIZE_W-1:0]     size_n;
  logic [NUM_W-1:0]      num;
  logic [NUM_W-1:0]      dsh_ext;
  logic                  take;
  logic [OUT_W+LEVEL_BITS-1:0] quot_ext;
  logic [OUT_W-1:0]      lut_wdata;
  logic [OUT_W-1:0]      lut_rdata;

  // Histogram bins; a bin whose valid bit is low reads as zero.
  heq_ram #(.WIDTH(BIN_W), .DEPTH(LEVEL_COUNT)) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.hist_inc),
    .waddr_i (lvl_q),
    .wdata_i (bin_inc),
    .re_i    (cmd_i.hist_rd),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  // Equalisation lookup table.
  heq_ram #(.WIDTH(OUT_W), .DEPTH(LEVEL_COUNT)) u_lut_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.lut_wr),
    .waddr_i (bld_lvl_q),
    .wdata_i (lut_wdata),
    .re_i    (cmd_i.lut_rd),
    .raddr_i (lvl_q),
    .rdata_o (lut_rdata)
  );

  assign hist_raddr = cmd_i.rd_bld ? bld_lvl_q : lvl_q;

  // Bin value and its saturating increment.
  assign bin_cur = rd_vld_q ? hist_rdata : '0;
  assign bin_inc = (bin_cur == BIN_MAX) ? bin_cur : bin_cur + 1'b1;

  // Numerator of the rounded normalisation; a zero size counts as one.
  assign size_n = (image_size_i == '0) ? SIZE_W'(1) : image_size_i;
  assign num    = NUM_W'(cum_q) * NUM_W'(TWO_MAX_LEVEL) + NUM_W'(size_n);

  // One restoring division step per cycle.
  assign dsh_ext = NUM_W'(dsh_q);
  assign take    = (rem_q >= dsh_ext);

  // Table entry, saturated when the cumulative count exceeds the size.
  assign quot_ext  = {{OUT_W{1'b0}}, quot_q};
  assign lut_wdata = sat_q ? MAX_LEVEL_OUT : quot_ext[OUT_W-1:0];

  // Histogram valid bits and the valid flag of the last read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_vld_q <= '0;
      rd_vld_q   <= 1'b0;
    end else begin
      if (cmd_i.hist_clr) begin
        hist_vld_q <= '0;
      end else if (cmd_i.hist_inc) begin
        hist_vld_q[lvl_q] <= 1'b1;
      end
      if (cmd_i.hist_rd) begin
        rd_vld_q <= hist_vld_q[hist_raddr];
      end
    end
  end

  // Item level and build level counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q     <= '0;
      bld_lvl_q <= '0;
      step_q    <= '0;
    end else begin
      if (cmd_i.lvl_load) begin
        lvl_q <= level_of(pixel_i);
      end
      if (cmd_i.bld_start) begin
        bld_lvl_q <= '0;
      end else if (cmd_i.bld_next) begin
        bld_lvl_q <= bld_lvl_q + 1'b1;
      end
      if (cmd_i.num_load) begin
        step_q <= STEP_W'(LEVEL_BITS - 1);
      end else if (cmd_i.div_step) begin
        step_q <= step_q - 1'b1;
      end
    end
  end

  // Cumulative count, normalisation and divider registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.bld_start) begin
      cum_q <= '0;
    end else if (cmd_i.cum_acc) begin
      cum_q <= cum_q + CUM_W'(bin_cur);
    end
    if (cmd_i.num_load) begin
      rem_q  <= num;
      dsh_q  <= DSH_W'({size_n, 1'b0}) << (LEVEL_BITS - 1);
      quot_q <= '0;
      sat_q  <= (WIDE_W'(cum_q) > WIDE_W'(size_n));
    end else if (cmd_i.div_step) begin
      if (take) begin
        rem_q <= rem_q - dsh_ext;
      end
      dsh_q  <= dsh_q >> 1;
      quot_q <= (quot_q << 1) | LEVEL_BITS'(take);
    end
    if (cmd_i.out_load) begin
      out_q <= lut_rdata;
    end
  end

  assign sts_o.bld_last  = (bld_lvl_q == MAX_LEVEL);
  assign sts_o.div_last  = (step_q == '0);
  assign mapped_pixel_o  = out_q;

endmodule

FILE: hdl/heq_ctrl.sv
`timescale 1ns / 1ps
`include "histogram_equalizer_defines.svh"

module heq_ctrl import heq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [OPCODE_W-1:0] in_opcode_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dp_cmd_t             cmd_o,
  input  dp_sts_t             sts_i
);

  state_e state_q, state_d;
  logic   tbl_ready_q, tbl_ready_d;
  logic   out_vld_q, out_vld_d;

  // State, table flag and output beat flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tbl_ready_q <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      tbl_ready_q <= tbl_ready_d;
      out_vld_q   <= out_vld_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d     = state_q;
    tbl_ready_d = tbl_ready_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.lvl_load = 1'b1;
          case (op_e'(in_opcode_i))
            OP_COUNT: begin
              tbl_ready_d = 1'b0;
              state_d     = ST_CNT_RD;
            end
            OP_MAP: begin
              if (tbl_ready_q) begin
                state_d = ST_MAP_RD;
              end else begin
                cmd_o.bld_start = 1'b1;
                state_d         = ST_BLD_RD;
              end
            end
            OP_CLEAR: begin
              cmd_o.hist_clr = 1'b1;
              tbl_ready_d    = 1'b0;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_CNT_RD: begin
        cmd_o.hist_rd = 1'b1;
        state_d       = ST_CNT_WR;
      end
      ST_CNT_WR: begin
        cmd_o.hist_inc = 1'b1;
        state_d        = ST_IDLE;
      end
      ST_BLD_RD: begin
        cmd_o.hist_rd = 1'b1;
        cmd_o.rd_bld  = 1'b1;
        state_d       = ST_BLD_ACC;
      end
      ST_BLD_ACC: begin
        cmd_o.cum_acc = 1'b1;
        state_d       = ST_BLD_NUM;
      end
      ST_BLD_NUM: begin
        cmd_o.num_load = 1'b1;
        state_d        = ST_BLD_DIV;
      end
      ST_BLD_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_BLD_WR;
        end
      end
      ST_BLD_WR: begin
        cmd_o.lut_wr = 1'b1;
        if (sts_i.bld_last) begin
          tbl_ready_d = 1'b1;
          state_d     = ST_MAP_RD;
        end else begin
          cmd_o.bld_next = 1'b1;
          state_d        = ST_BLD_RD;
        end
      end
      ST_MAP_RD: begin
        cmd_o.lut_rd = 1'b1;
        state_d      = ST_MAP_OUT;
      end
      ST_MAP_OUT: begin
        if (!out_vld_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // The output beat stays until taken; a new result may replace it in the same cycle.
  always_comb begin
    if (cmd_o.out_load) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  assign out_valid_o = out_vld_q;

  // A counted pixel always invalidates the table.
  `HEQ_ASSERT_NEXT(a_count_drops_table, in_valid_i && in_ready_o && (in_opcode_i == OP_COUNT), !tbl_ready_q, "table still marked ready after a count beat")
  // A build only starts from a stale table.
  `HEQ_ASSERT(a_build_on_stale, (state_q == ST_BLD_RD) |-> !tbl_ready_q, "table build while table is ready")
  // A result is only loaded into a free or draining output register.
  `HEQ_ASSERT(a_out_slot_free, cmd_o.out_load |-> (!out_vld_q || out_ready_i), "result overwrote a waiting output beat")
  // The table becomes ready only at the end of a build.
  `HEQ_ASSERT(a_ready_after_build, $rose(tbl_ready_q) |-> $past(state_q == ST_BLD_WR), "table marked ready outside a build")

endmodule

FILE: hdl/histogram_equalizer.sv
`timescale 1ns / 1ps
// Channel   Direction  Bits                     Contents
// s_axis    in         tuser[1:0], tdata[7:0]   opcode, pixel
// m_axis    out        tdata[7:0]               mapped_pixel (map beats only)
// apb       in/out     paddr[2:0], 32-bit data  image_size at byte address 0
//
// A count beat reads and then writes its bin; a clear beat clears all bins in idle;
// a map beat with a ready table reads the table, then loads the output register.
// The first map beat after a count or clear first builds the table, for each level:
// histogram read, accumulate, numerator load, one-bit-per-cycle divide, table write.
// Reset is asynchronous and active low; the histogram reads as all zero after it.
// A finished result waits in the output register while count and clear beats go on.

module histogram_equalizer import heq_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input stream
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [PIXEL_W-1:0]    s_axis_tdata_i,   // [7:0] pixel
  input  logic [OPCODE_W-1:0]   s_axis_tuser_i,   // [1:0] opcode
  // Output stream
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_W-1:0]      m_axis_tdata_o,   // [7:0] mapped_pixel
  // Configuration port
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic [APB_ADDR_W-1:0] paddr_i,
  input  logic [APB_DATA_W-1:0] pwdata_i,
  output logic [APB_DATA_W-1:0] prdata_o,
  output logic                  pready_o
);

  logic [SIZE_W-1:0] image_size_q;
  logic              reg_sel;
  logic              apb_wr;
  dp_cmd_t           cmd;
  dp_sts_t           sts;

  // Register write on the access phase.
  assign pready_o = 1'b1;
  assign reg_sel  = paddr_i[APB_ADDR_W-1];
  assign apb_wr   = psel_i && penable_i && pwrite_i && pready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_size_q <= SIZE_W'(1);
    end else if (apb_wr && (reg_sel == REG_IMAGE_SIZE)) begin
      image_size_q <= pwdata_i[SIZE_W-1:0];
    end
  end

  // Register read.
  assign prdata_o = (reg_sel == REG_IMAGE_SIZE) ? APB_DATA_W'(image_size_q) : '0;

  heq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_opcode_i (s_axis_tuser_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  heq_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .pixel_i        (s_axis_tdata_i),
    .image_size_i   (image_size_q),
    .mapped_pixel_o (m_axis_tdata_o)
  );

endmodule

FILE: dv/tb_histogram_equalizer.sv
`timescale 1ns / 1ps

module tb_histogram_equalizer;
  import heq_pkg::*;

  // Opcode that the block accepts and drops without a result.
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  localparam int ITEM_TARGET = 1025;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE      = 8;
  localparam int TAIL        = 20;

  typedef enum logic {
    ROW_ITEM,
    ROW_SIZE
  } row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    logic [OPCODE_W-1:0] op;
    logic [PIXEL_W-1:0]  pixel;
    logic [SIZE_W-1:0]   size;
    logic                fixed;
    logic [OUT_W-1:0]    fixed_px;
  } plan_row_t;

  localparam int PLAN_ROWS = 29;

  // Directed opening: empty histogram, zero and extreme sizes, rounding ties,
  // saturation, the unused opcode and a size change after the table is built.
  plan_row_t plan [PLAN_ROWS] = '{
    '{ROW_ITEM, OP_MAP,    8'd0,   25'd0,        1'b1, 8'd0},
    '{ROW_ITEM, OP_MAP,    8'd255, 25'd0,        1'b1, 8'd0},
    '{ROW_SIZE, OP_COUNT,  8'd0,   25'd0,        1'b0, 8'd0},
    '{ROW_ITEM, OP_COUNT,  8'd0,   25'd0,        1'b0, 8'd0},
    '{ROW_ITEM, OP_COUNT,  8'd255, 25'd0,        1'b0, 8'd0},
    '{ROW_ITEM, OP_MAP,    8'd0,   25'd0,        1'b1, 8'd255},
    '{ROW_ITEM, OP_UNUSED, 8'hAA,  25'd0,        1'b0, 8'd0},
    '{ROW_SIZE, OP_COUNT,  8'd0,   25'd4,        1'b0, 8'd0},
    '{ROW_ITEM, OP_MAP,    8'd128, 25'd0,        1'b1, 8'd255},
    '{ROW_ITEM, OP_COUNT,  8'd128, 25'd0,        1'b0, 8'd0},
    '{ROW_ITEM, OP_MAP,    8'd128, 25'd0,        1'b0, 8'd0},
    '{ROW_ITEM, OP_MAP,    8'd255, 25'd0,        1'b0, 8'd0},
    '{ROW_ITEM, OP_CLEAR,  8'h55,  25'd0,        1'b0, 8'd0},
    '{ROW_ITEM, OP_MAP,    8'd7,   25'd0,        1'b1, 8'd0},
    '{ROW_SIZE, OP_COUNT,  8'd0,   25'h1FFFFFF,  1'b0, 8'd0},
    '{ROW_ITEM, OP_COUNT,  8'd85,  25'd0,        1'b0, 8'd0},
    '{ROW_ITEM, OP_MAP,    8'd85,  25'd0,        1'b1, 8'd0},
    '{ROW_SIZE, OP_COUNT,  8'd0,   25'd16777216, 1'b0, 8'd0},
    '{ROW_ITEM, OP_COUNT,  8'd170, 25'd0,        1'b0, 8'd0},
    '{ROW_ITEM, OP_MAP,    8'd255, 25'd0,        1'b1, 8'd0},
    '{ROW_SIZE, OP_COUNT,  8'd0,   25'd2,        1'b0, 8'd0},
    '{ROW_ITEM, OP_CLEAR,  8'd0,   25'd0,        1'b0, 8'd0},
    '{ROW_ITEM, OP_COUNT,  8'd1,   25'd0,        1'b0, 8'd0},
    '{ROW_ITEM, OP_MAP,    8'd1,   25'd0,        1'b1, 8'd128},
    '{ROW_ITEM, OP_COUNT,  8'd1,   25'd0,        1'b0, 8'd0},
    '{ROW_ITEM, OP_COUNT,  8'd1,   25'd0,        1'b0, 8'd0},
    '{ROW_ITEM, OP_MAP,    8'd0,   25'd0,        1'b1, 8'd0},
    '{ROW_ITEM, OP_MAP,    8'd1,   25'd0,        1'b1, 8'd255},
    '{ROW_ITEM, OP_MAP,    8'd254, 25'd0,        1'b0, 8'd0}
  };

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic                  s_valid = 1'b0;
  logic [PIXEL_W-1:0]    s_data  = '0;
  logic [OPCODE_W-1:0]   s_user  = '0;
  logic                  s_axis_tready_o;
  logic                  m_axis_tvalid_o;
  logic                  m_ready = 1'b0;
  logic [OUT_W-1:0]      m_axis_tdata_o;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata_o;
  logic                  pready_o;

  histogram_equalizer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_o        (prdata_o),
    .pready_o        (pready_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the block: histogram, lookup table and the image size register.
  logic [BIN_W-1:0]  hist_bins [LEVEL_COUNT];
  logic [OUT_W-1:0]  eq_lut    [LEVEL_COUNT];
  bit                lut_valid;
  logic [SIZE_W-1:0] size_cfg;

  logic [OUT_W-1:0] mapped_q [$];

  int fail_count;
  int items_sent;
  int count_beats;
  int map_beats;
  int clear_beats;
  int dropped_beats;
  int lut_builds;
  int size_writes;
  int results_seen;
  int burst_left;
  bit quiet;

  task automatic report(input string msg);
    if (fail_count < 30) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    fail_count++;
  endtask

  // Cumulative histogram scaled to the top level, rounded half up.
  function automatic void rebuild_lut();
    longint unsigned n;
    longint unsigned cum;
    longint unsigned q;
    n   = (size_cfg == '0) ? 64'd1 : 64'(size_cfg);
    cum = 0;
    for (int l = 0; l < LEVEL_COUNT; l++) begin
      cum += 64'(hist_bins[l]);
      q = (2 * cum * (LEVEL_COUNT - 1) + n) / (2 * n);
      if (q > LEVEL_COUNT - 1) begin
        q = LEVEL_COUNT - 1;
      end
      eq_lut[l] = OUT_W'(q);
    end
    lut_valid = 1'b1;
    lut_builds++;
  endfunction

  // Applies one accepted beat to the shadow and gives its mapped pixel, if any.
  function automatic void equalize_item(input logic [OPCODE_W-1:0] op,
                                        input logic [PIXEL_W-1:0] pix,
                                        output bit has_px, output logic [OUT_W-1:0] px);
    int lvl;
    // An 8-bit pixel never exceeds the 256 levels, so no clamping is needed.
    lvl    = int'(pix);
    has_px = 1'b0;
    px     = '0;
    if (op == OP_COUNT) begin
      if (hist_bins[lvl] != BIN_MAX) begin
        hist_bins[lvl] = hist_bins[lvl] + 1'b1;
      end
      lut_valid = 1'b0;
      count_beats++;
    end else if (op == OP_MAP) begin
      if (!lut_valid) begin
        rebuild_lut();
      end
      has_px = 1'b1;
      px     = eq_lut[lvl];
      map_beats++;
    end else if (op == OP_CLEAR) begin
      for (int l = 0; l < LEVEL_COUNT; l++) begin
        hist_bins[l] = '0;
      end
      lut_valid = 1'b0;
      clear_beats++;
    end else begin
      dropped_beats++;
    end
  endfunction

  // Sends one beat in bursts with random gaps, then records what it must produce.
  task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [PIXEL_W-1:0] pix,
                           input bit use_fixed = 1'b0, input logic [OUT_W-1:0] fixed_px = '0);
    int               gap;
    bit               has_px;
    logic [OUT_W-1:0] px;
    if (burst_left == 0) begin
      gap = quiet ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_valid <= 1'b1;
    s_data  <= pix;
    s_user  <= op;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    burst_left--;
    equalize_item(op, pix, has_px, px);
    if (op != OP_UNUSED) begin
      items_sent++;
    end
    if (has_px) begin
      mapped_q.push_back(use_fixed ? fixed_px : px);
    end
  endtask

  // Holds the input back until every mapped pixel has come, then lets the block settle.
  task automatic drain();
    s_valid <= 1'b0;
    while (mapped_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic apb_cycle(input bit wr, input logic [APB_DATA_W-1:0] wdata,
                           output logic [APB_DATA_W-1:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= APB_ADDR_W'(4 * REG_IMAGE_SIZE);
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready_o) @(posedge clk_i);
    rdata = prdata_o;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes the image size while the block is idle and reads it back.
  task automatic set_image_size(input logic [SIZE_W-1:0] value);
    logic [APB_DATA_W-1:0] rd;
    drain();
    apb_cycle(1'b1, APB_DATA_W'(value), rd);
    size_cfg = value;
    size_writes++;
    apb_cycle(1'b0, '0, rd);
    if (rd !== APB_DATA_W'(value)) begin
      report($sformatf("image_size read back %0d, wrote %0d", rd, value));
    end
  endtask

  function automatic logic [PIXEL_W-1:0] band_pixel(input int base, input int spread);
    return PIXEL_W'(base + int'($urandom_range(0, spread)));
  endfunction

  // Random images: size, usually a clear, a run of counts in a brightness band, then maps,
  // with the odd dropped opcode, early map or late count mixed in.
  task automatic run_images();
    int                npix;
    int                nmap;
    int                base;
    int                spread;
    logic [SIZE_W-1:0] size_val;
    while (items_sent < ITEM_TARGET) begin
      npix = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 48);
      case ($urandom_range(0, 9))
        6:       size_val = SIZE_W'($urandom_range(1, 2 * npix));
        7:       size_val = '0;
        8:       size_val = $urandom_range(0, 1) ? SIZE_W'(16777216) : {SIZE_W{1'b1}};
        9:       size_val = SIZE_W'($urandom_range(1, 33554431));
        default: size_val = SIZE_W'(npix);
      endcase
      set_image_size(size_val);
      quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 5) != 0) begin
        send_item(OP_CLEAR, PIXEL_W'($urandom));
      end
      base   = $urandom_range(0, 255);
      spread = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(0, 80);
      repeat (npix) begin
        case ($urandom_range(0, 39))
          0:       send_item(OP_UNUSED, PIXEL_W'($urandom));
          1:       send_item(OP_MAP, band_pixel(base, spread));
          default: send_item(OP_COUNT, band_pixel(base, spread));
        endcase
      end
      nmap = $urandom_range(4, 32);
      repeat (nmap) begin
        case ($urandom_range(0, 19))
          0:       send_item(OP_COUNT, PIXEL_W'($urandom));
          1:       send_item(OP_UNUSED, PIXEL_W'($urandom));
          2:       send_item(OP_MAP, PIXEL_W'($urandom));
          default: send_item(OP_MAP, band_pixel(base, spread));
        endcase
      end
    end
  endtask

  // Receiver: ready pattern, redrawn periodically from four random modes.
  int rx_tick;
  int rx_mode;

  always @(posedge clk_i) begin
    rx_tick++;
    if (rx_tick % 256 == 0) begin
      rx_mode = $urandom_range(0, 3);
    end
    case (rx_mode)
      0:       m_ready <= 1'b1;
      1:       m_ready <= ($urandom_range(0, 9) < 7);
      2:       m_ready <= ($urandom_range(0, 9) < 2);
      default: m_ready <= rx_tick[2];
    endcase
  end

  // Each result beat is checked against the oldest mapped pixel waiting.
  logic [OUT_W-1:0] want_px;

  always @(posedge clk_i) begin
    if (rst_n && m_axis_tvalid_o && m_ready) begin
      if (mapped_q.size() == 0) begin
        report($sformatf("result %0d with nothing outstanding", m_axis_tdata_o));
      end else begin
        want_px = mapped_q.pop_front();
        results_seen++;
        if (m_axis_tdata_o !== want_px) begin
          report($sformatf("mapped_pixel %0d, predicted %0d", m_axis_tdata_o, want_px));
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat or register access.
  int stall_cycles;

  always @(posedge clk_i) begin
    if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready) || (psel && penable)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("Watchdog: no beat accepted for %0d cycles, %0d results outstanding",
               STALL_LIMIT, mapped_q.size());
      $display("** histogram_equalizer: FAILED **");
      $finish;
    end
  end

  initial begin
    for (int l = 0; l < LEVEL_COUNT; l++) begin
      hist_bins[l] = '0;
      eq_lut[l]    = '0;
    end
    lut_valid  = 1'b0;
    size_cfg   = SIZE_W'(1);
    burst_left = 0;
    quiet      = 1'b0;

    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed rows.
    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (plan[i].kind == ROW_SIZE) begin
        set_image_size(plan[i].size);
      end else begin
        send_item(plan[i].op, plan[i].pixel, plan[i].fixed, plan[i].fixed_px);
      end
    end

    run_images();

    // Let everything drain, then let the block run on before the summary.
    s_valid <= 1'b0;
    while (mapped_q.size() != 0) @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);

    $display("Covered %0d count, %0d map, %0d clear and %0d dropped beats; %0d results.",
             count_beats, map_beats, clear_beats, dropped_beats, results_seen);
    $display("Lookup table rebuilt %0d times over %0d image size settings.",
             lut_builds, size_writes);
    if (fail_count == 0) begin
      $display("** histogram_equalizer: PASSED **");
    end else begin
      $display("** histogram_equalizer: FAILED **");
    end
    $finish;
  end

endmodule
